[sv/mmosc_pkg.sv]
// Package: shared constants and types for the output switch controller.
`timescale 1ns / 1ps
package mmosc_pkg;
  localparam int unsigned PwmOutputDefault = 1;
  localparam int unsigned TicksPerSecondDefault = 1000;

  typedef enum logic [2:0] {
    MODE_DOWN = 3'd0, MODE_ON = 3'd1, MODE_TIMED = 3'd2, MODE_COUNT = 3'd3,
    MODE_LEVEL = 3'd4, MODE_INTERVAL = 3'd5, MODE_LEVEL2 = 3'd6, MODE_BAD = 3'd7
  } mode_t;

  localparam logic [2:0] REG_DURATION = 3'd0;
  localparam logic [2:0] REG_STEP_TARGET = 3'd1;
  localparam logic [2:0] REG_STEP_DIVISOR = 3'd2;
  localparam logic [2:0] REG_AUTO_LOW = 3'd3;
  localparam logic [2:0] REG_AUTO_HIGH = 3'd4;
  localparam logic [2:0] REG_AUTO_DELAY = 3'd5;
  localparam logic [2:0] REG_INTERVAL_ON = 3'd6;
  localparam logic [2:0] REG_INTERVAL_OFF = 3'd7;

  // divider control between sequencer and shared unit
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage

[sv/mmosc_divider.sv]
// Shared restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module mmosc_divider (
  input  logic                clk,
  input  logic                rst,
  input  mmosc_pkg::div_req_t req,
  output mmosc_pkg::div_rsp_t rsp
);
  import mmosc_pkg::*;

  logic [5:0]  count;
  logic [31:0] quo;
  logic [16:0] rem;
  logic [15:0] dsr;
  logic [16:0] shifted;
  logic        busy;

  assign shifted = {rem[15:0], quo[31]};
  assign rsp.busy = busy;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      count <= 6'd32;
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      if (shifted >= {1'b0, dsr}) begin
        rem <= shifted - {1'b0, dsr};
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[30:0], 1'b0};
      end
      count <= count - 6'd1;
      if (count == 6'd1) busy <= 1'b0;
    end
  end
endmodule

[sv/multi_mode_output_switch_controller.sv]
// Top level: multi-mode pump/load switch controller with stream ports.
`timescale 1ns / 1ps
// Each accepted beat is either a 1 ms tick or a mode command and yields one
// result beat. When step_divisor is nonzero, the dispense count (on-time
// divided by step_divisor) is computed on every beat by a shared bit-serial
// divider, one quotient bit per cycle; otherwise it is all ones. The input is
// not ready until the result has been taken from the output register. Seconds
// limits are scaled to milliseconds by one 16-bit by TICKS_PER_SECOND multiply
// per beat. Config writes are taken any time and must only occur while the
// block is idle.
module multi_mode_output_switch_controller #(
  parameter int unsigned PWM_OUTPUT = mmosc_pkg::PwmOutputDefault,
  parameter int unsigned TICKS_PER_SECOND = mmosc_pkg::TicksPerSecondDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: new_mode[2:0], mode_limit_s[18:3], enable[19], level_sample[31:20],
  // duty[39:32]
  input  logic [39:0] s_tdata,
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: drive_on[0], drive_level[8:1], mode_now[11:9], mode_publish[12],
  // state_publish[13], last_dispensed[45:14], zero fill to 48
  output logic [47:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mmosc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EXEC, S_OUT} seq_t;

  // config
  logic [15:0] duration_limit_s, step_divisor, auto_delay_s, interval_on_s, interval_off_s;
  logic [31:0] step_target;
  logic [11:0] auto_low, auto_high;
  // state
  mode_t       cur_mode;
  logic        is_on, delay_armed, interval_started, interval_odd;
  logic [7:0]  held_duty;
  logic [31:0] on_time_ms, delay_ms, phase_ms, dispensed_latch;
  logic [15:0] held_limit_s;
  // latched beat
  seq_t        seq;
  logic        func, enable;
  logic [2:0]  new_mode;
  logic [15:0] mode_limit_s;
  logic [11:0] level_sample;
  logic [7:0]  duty;
  logic [31:0] disp;
  logic [47:0] obuf;

  div_req_t div_req;
  div_rsp_t div_rsp;

  mmosc_divider u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // on-time after this beat's increment for a tick
  logic [31:0] on_inc, delay_inc, phase_inc;
  assign on_inc    = (on_time_ms == '1) ? on_time_ms : on_time_ms + 32'd1;
  assign delay_inc = (delay_ms == '1) ? delay_ms : delay_ms + 32'd1;
  assign phase_inc = (phase_ms == '1) ? phase_ms : phase_ms + 32'd1;

  assign s_tready = (seq == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid = (seq == S_OUT);
  assign m_tdata = obuf;

  always_comb begin
    div_req.start = (seq == S_IDLE) && s_tvalid && (step_divisor != '0);
    div_req.dividend = (s_tuser == 1'b0) ? on_inc : on_time_ms;
    div_req.divisor = step_divisor;
  end

  // ms limits: one shared multiply, operand picked by mode (registered in S_DIV)
  logic [15:0] lim_sel;
  logic [51:0] lim_ms;
  always_comb begin
    case (cur_mode)
      MODE_TIMED: lim_sel = duration_limit_s;
      MODE_LEVEL, MODE_LEVEL2: lim_sel = (is_on || !(level_sample <= auto_low))
                                         ? held_limit_s : auto_delay_s;
      MODE_INTERVAL: lim_sel = !interval_started ? held_limit_s
                                : (interval_odd ? interval_on_s : interval_off_s);
      default: lim_sel = held_limit_s;
    endcase
  end
  logic [51:0] lim_prod;
  assign lim_prod = 52'(lim_sel) * 52'(TICKS_PER_SECOND);

  // sequencer and state update
  always_ff @(posedge clk) begin
    logic        on_n, arm_n, st_n, odd_n, mp, sp;
    logic [7:0]  hd_n;
    logic [31:0] ot_n, dl_n, ph_n, lat_n;
    mode_t       md_n;
    logic [15:0] hl_n;
    logic        lo;
    if (rst) begin
      seq <= S_IDLE;
      duration_limit_s <= '0; step_target <= '0; step_divisor <= 16'd1;
      auto_low <= '0; auto_high <= 12'hFFF; auto_delay_s <= '0;
      interval_on_s <= '0; interval_off_s <= '0;
      cur_mode <= MODE_DOWN; is_on <= 1'b0; held_duty <= '0; on_time_ms <= '0;
      dispensed_latch <= '0; delay_armed <= 1'b0; delay_ms <= '0;
      held_limit_s <= '0; interval_started <= 1'b0; interval_odd <= 1'b0;
      phase_ms <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_DURATION:     duration_limit_s <= cfg_data[15:0];
          REG_STEP_TARGET:  step_target <= cfg_data;
          REG_STEP_DIVISOR: step_divisor <= cfg_data[15:0];
          REG_AUTO_LOW:     auto_low <= cfg_data[11:0];
          REG_AUTO_HIGH:    auto_high <= cfg_data[11:0];
          REG_AUTO_DELAY:   auto_delay_s <= cfg_data[15:0];
          REG_INTERVAL_ON:  interval_on_s <= cfg_data[15:0];
          REG_INTERVAL_OFF: interval_off_s <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (seq)
        S_IDLE: begin
          if (s_tvalid) begin
            func <= s_tuser;
            new_mode <= s_tdata[2:0];
            mode_limit_s <= s_tdata[18:3];
            enable <= s_tdata[19];
            level_sample <= s_tdata[31:20];
            duty <= s_tdata[39:32];
            seq <= S_DIV;
          end
        end
        S_DIV: begin
          lim_ms <= lim_prod;
          if (!div_rsp.busy) begin
            disp <= (step_divisor == '0) ? 32'hFFFF_FFFF : div_rsp.quotient;
            seq <= S_EXEC;
          end
        end
        S_EXEC: begin
          on_n = is_on; hd_n = held_duty; ot_n = on_time_ms; dl_n = delay_ms;
          ph_n = phase_ms; lat_n = dispensed_latch; md_n = cur_mode;
          hl_n = held_limit_s; arm_n = delay_armed; st_n = interval_started;
          odd_n = interval_odd; mp = 1'b0; sp = 1'b0;
          lo = (level_sample <= auto_low);
          if (func) begin
            case (new_mode)
              MODE_DOWN, MODE_ON: md_n = mode_t'(new_mode);
              MODE_TIMED, MODE_COUNT, MODE_LEVEL, MODE_LEVEL2: begin
                md_n = mode_t'(new_mode);
                if (is_on) begin lat_n = disp; on_n = 1'b0; hd_n = '0; end
                if (new_mode == MODE_LEVEL || new_mode == MODE_LEVEL2) hl_n = mode_limit_s;
              end
              MODE_INTERVAL: begin
                st_n = 1'b0; odd_n = 1'b0;
                if (is_on) begin lat_n = disp; on_n = 1'b0; hd_n = '0; end
                md_n = MODE_INTERVAL; ph_n = '0; hl_n = mode_limit_s;
              end
              default: ;
            endcase
          end else begin
            ot_n = on_inc; dl_n = delay_inc; ph_n = phase_inc;
            if (!enable) md_n = MODE_DOWN;
            else begin
              case (cur_mode)
                MODE_ON: if (!is_on) begin
                  ot_n = '0; hd_n = duty; on_n = !(PWM_OUTPUT != 0 && duty == '0); mp = 1'b1;
                end
                MODE_DOWN: if (is_on) begin
                  lat_n = disp; on_n = 1'b0; hd_n = '0; mp = 1'b1;
                end
                MODE_TIMED: begin
                  if (is_on) begin
                    if (52'(on_inc) > lim_ms) begin
                      lat_n = disp; on_n = 1'b0; hd_n = '0; sp = 1'b1; md_n = MODE_DOWN;
                    end
                  end else if (duration_limit_s != '0) begin
                    ot_n = '0; hd_n = duty; on_n = !(PWM_OUTPUT != 0 && duty == '0); sp = 1'b1;
                  end else begin md_n = MODE_DOWN; mp = 1'b1; end
                end
                MODE_COUNT: begin
                  if (is_on) begin
                    if (disp > step_target) begin
                      lat_n = disp; on_n = 1'b0; hd_n = '0; sp = 1'b1; md_n = MODE_DOWN;
                    end
                  end else if (step_target != '0) begin
                    ot_n = '0; hd_n = duty; on_n = !(PWM_OUTPUT != 0 && duty == '0); sp = 1'b1;
                  end else begin md_n = MODE_DOWN; mp = 1'b1; end
                end
                MODE_LEVEL, MODE_LEVEL2: begin
                  if (lo && !is_on) begin
                    if (!(auto_low == auto_high && level_sample == auto_low)) begin
                      if (!delay_armed) begin dl_n = '0; arm_n = 1'b1; end
                      if (52'(dl_n) >= lim_ms) begin
                        ot_n = '0; hd_n = duty;
                        on_n = !(PWM_OUTPUT != 0 && duty == '0); arm_n = 1'b0;
                      end
                    end
                  end else if (!lo && !is_on) arm_n = 1'b0;
                  else if (level_sample >= auto_high && is_on) begin
                    lat_n = disp; on_n = 1'b0; hd_n = '0;
                  end
                  // held_limit_s compare only matters when still on; then lim_ms
                  // was taken from held_limit_s (the switch-on path clears ot_n)
                  if (on_n && (is_on ? (52'(ot_n) >= lim_ms)
                                     : (held_limit_s == '0))) md_n = MODE_DOWN;
                end
                MODE_INTERVAL: begin
                  if (interval_started) begin
                    if (interval_odd) begin
                      if (52'(phase_inc) >= lim_ms) begin
                        lat_n = disp; on_n = 1'b0; hd_n = '0; mp = 1'b1;
                        ph_n = '0; odd_n = 1'b0;
                      end
                    end else if (52'(phase_inc) >= lim_ms) begin
                      ph_n = '0; ot_n = '0; hd_n = duty;
                      on_n = !(PWM_OUTPUT != 0 && duty == '0); mp = 1'b1; odd_n = 1'b1;
                    end
                  end else if (52'(phase_inc) >= lim_ms) begin
                    ph_n = '0; ot_n = '0; hd_n = duty;
                    on_n = !(PWM_OUTPUT != 0 && duty == '0); mp = 1'b1;
                    st_n = 1'b1; odd_n = 1'b1;
                  end
                end
                default: md_n = MODE_DOWN;
              endcase
            end
          end
          is_on <= on_n; held_duty <= hd_n; on_time_ms <= ot_n; delay_ms <= dl_n;
          phase_ms <= ph_n; dispensed_latch <= lat_n; cur_mode <= md_n;
          held_limit_s <= hl_n; delay_armed <= arm_n; interval_started <= st_n;
          interval_odd <= odd_n;
          obuf <= {2'b00, lat_n, sp, mp, md_n,
                   on_n ? ((PWM_OUTPUT != 0) ? hd_n : 8'hFF) : 8'h00, on_n};
          seq <= S_OUT;
        end
        S_OUT: if (m_tready) seq <= S_IDLE;
        default: seq <= S_IDLE;
      endcase
    end
  end
endmodule

[tb/multi_mode_output_switch_controller_tb.sv]
// Testbench: self-checking stream test of the multi-mode output switch controller.
`timescale 1ns / 1ps
module multi_mode_output_switch_controller_tb;
  import mmosc_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned RandomItems = 1700;

  // Predicts the switch controller beat by beat and holds the results still owed.
  class switch_scoreboard;
    logic [15:0] dur_s, div, dly_s, on_s, off_s, lim_s;
    logic [31:0] target, on_ms, latch, dly_ms, ph_ms;
    logic [11:0] lo, hi;
    logic [7:0]  duty_q;
    mode_t       mode;
    bit          on, armed, started, odd;
    logic [47:0] result_q[$];
    int          errors, n_in, n_out, n_cmd, n_mpub, n_spub;

    function new();
      dur_s = 0; target = 0; div = 1; lo = 0; hi = 12'hfff; dly_s = 0;
      on_s = 0; off_s = 0; mode = MODE_DOWN; on = 0; duty_q = 0; on_ms = 0;
      latch = 0; armed = 0; dly_ms = 0; lim_s = 0; started = 0; odd = 0;
      ph_ms = 0; errors = 0; n_in = 0; n_out = 0; n_cmd = 0; n_mpub = 0; n_spub = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_DURATION:     dur_s = d[15:0];
        REG_STEP_TARGET:  target = d;
        REG_STEP_DIVISOR: div = d[15:0];
        REG_AUTO_LOW:     lo = d[11:0];
        REG_AUTO_HIGH:    hi = d[11:0];
        REG_AUTO_DELAY:   dly_s = d[15:0];
        REG_INTERVAL_ON:  on_s = d[15:0];
        REG_INTERVAL_OFF: off_s = d[15:0];
        default: ;
      endcase
    endfunction

    function longint unsigned ms(logic [15:0] s);
      return longint'(s) * TicksPerSecondDefault;
    endfunction

    function logic [31:0] sat(logic [31:0] v);
      return (v == 32'hffff_ffff) ? v : v + 1;
    endfunction

    function logic [31:0] units();
      return (div == 0) ? 32'hffff_ffff : on_ms / div;
    endfunction

    function void turn_on(logic [7:0] d);
      on_ms = 0;
      duty_q = d;
      on = (d != 0);
    endfunction

    function void turn_off();
      latch = units();
      on = 0;
      duty_q = 0;
    endfunction

    function void note_item(bit func, logic [39:0] d);
      logic [2:0]  m;
      logic [15:0] lim;
      bit          en, mp, sp;
      logic [11:0] lvl;
      logic [7:0]  dt;
      m = d[2:0]; lim = d[18:3]; en = d[19]; lvl = d[31:20]; dt = d[39:32];
      mp = 0; sp = 0;
      n_in++;
      if (func) begin
        n_cmd++;
        case (m)
          MODE_DOWN, MODE_ON: mode = mode_t'(m);
          MODE_TIMED, MODE_COUNT, MODE_LEVEL, MODE_LEVEL2: begin
            mode = mode_t'(m);
            if (on) turn_off();
            if (m == MODE_LEVEL || m == MODE_LEVEL2) lim_s = lim;
          end
          MODE_INTERVAL: begin
            started = 0; odd = 0;
            if (on) turn_off();
            mode = MODE_INTERVAL; ph_ms = 0; lim_s = lim;
          end
          default: ;  // unused code: ignored
        endcase
      end else begin
        on_ms = sat(on_ms); dly_ms = sat(dly_ms); ph_ms = sat(ph_ms);
        if (!en) mode = MODE_DOWN;
        else begin
          case (mode)
            MODE_ON: if (!on) begin turn_on(dt); mp = 1; end
            MODE_DOWN: if (on) begin turn_off(); mp = 1; end
            MODE_TIMED:
              if (on) begin
                if (longint'(on_ms) > ms(dur_s)) begin
                  turn_off(); sp = 1; mode = MODE_DOWN;
                end
              end else if (dur_s > 0) begin
                turn_on(dt); sp = 1;
              end else begin
                mode = MODE_DOWN; mp = 1;
              end
            MODE_COUNT:
              if (on) begin
                if (units() > target) begin
                  turn_off(); sp = 1; mode = MODE_DOWN;
                end
              end else if (target > 0) begin
                turn_on(dt); sp = 1;
              end else begin
                mode = MODE_DOWN; mp = 1;
              end
            MODE_LEVEL, MODE_LEVEL2: begin
              if (lvl <= lo && !on) begin
                if (!(lo == hi && lvl == lo)) begin
                  if (!armed) begin dly_ms = 0; armed = 1; end
                  if (longint'(dly_ms) >= ms(dly_s)) begin
                    turn_on(dt); armed = 0;
                  end
                end
              end else if (lvl > lo && !on) armed = 0;
              else if (lvl >= hi && on) turn_off();
              // max on-time only drops the mode; the drive follows next tick
              if (on && longint'(on_ms) >= ms(lim_s)) mode = MODE_DOWN;
            end
            MODE_INTERVAL:
              if (started) begin
                if (odd) begin
                  if (longint'(ph_ms) >= ms(on_s)) begin
                    turn_off(); mp = 1; ph_ms = 0; odd = 0;
                  end
                end else if (longint'(ph_ms) >= ms(off_s)) begin
                  ph_ms = 0; turn_on(dt); mp = 1; odd = 1;
                end
              end else if (longint'(ph_ms) >= ms(lim_s)) begin
                ph_ms = 0; turn_on(dt); mp = 1; started = 1; odd = 1;
              end
            default: mode = MODE_DOWN;
          endcase
        end
      end
      n_mpub += mp; n_spub += sp;
      result_q.push_back({2'b00, latch, sp, mp, 3'(mode), on ? duty_q : 8'd0, on});
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
      end
    endfunction

    function void check_result(logic [47:0] r);
      logic [47:0] e;
      n_out++;
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got %h", $time, r);
        return;
      end
      e = result_q.pop_front();
      cmp("drive_on", e[0], r[0]);
      cmp("drive_level", e[8:1], r[8:1]);
      cmp("mode_now", e[11:9], r[11:9]);
      cmp("mode_publish", e[12], r[12]);
      cmp("state_publish", e[13], r[13]);
      cmp("last_dispensed", e[45:14], r[45:14]);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  switch_scoreboard sb = new();
  bit          quiet = 0;     // no idling on either side
  bit          hold_req = 0;  // asks the receiver for one long hold-off
  int unsigned cycles = 0;

  always #4 clk = ~clk;

  multi_mode_output_switch_controller dut (.*);

  // Monitors: sample handshakes at the edge, before driven values change.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("multi_mode_output_switch_controller verification failed");
      $finish;
    end
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // Receiver: random ready bursts, one long hold-off on request.
  initial begin
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_tready <= 0;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_tready <= 1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // One edge first so the monitor has noted the last accepted beat.
  task automatic drain();
    @(posedge clk);
    while (sb.result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    s_tvalid <= 0;
    drain();
    repeat (50) @(posedge clk);  // margin so the block is idle before the write
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic send_beat(bit func, logic [39:0] d);
    s_tvalid <= 1; s_tuser <= func; s_tdata <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  // Sender gap after a beat; valid stays high when no gap is taken.
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic command(mode_t m, logic [15:0] lim);
    send_beat(1, {8'($urandom), 12'($urandom), 1'($urandom), lim, 3'(m)});
    sender_gap();
  endtask

  task automatic tick(bit en, logic [11:0] lvl, logic [7:0] dt);
    send_beat(0, {dt, lvl, en, 16'($urandom), 3'($urandom)});
    sender_gap();
  endtask

  function automatic logic [15:0] pick_secs();
    case ($urandom_range(0, 9))
      0: return 16'hffff;
      1, 2: return 1;
      default: return 0;
    endcase
  endfunction

  task automatic random_config();
    logic [11:0] a, b;
    a = $urandom_range(0, 9) == 0 ? 12'hfff : 12'($urandom);
    b = $urandom_range(0, 4) == 0 ? a : 12'($urandom);
    write_reg(REG_DURATION, pick_secs());
    write_reg(REG_STEP_TARGET, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 40));
    write_reg(REG_STEP_DIVISOR, $urandom_range(0, 9) == 0 ? $urandom_range(1, 65535)
                                                          : $urandom_range(1, 6));
    write_reg(REG_AUTO_LOW, a < b ? a : b);
    write_reg(REG_AUTO_HIGH, a < b ? b : a);
    write_reg(REG_AUTO_DELAY, pick_secs());
    write_reg(REG_INTERVAL_ON, pick_secs());
    write_reg(REG_INTERVAL_OFF, pick_secs());
  endtask

  task automatic random_beat();
    logic [11:0] lvl;
    case ($urandom_range(0, 3))
      0: lvl = $urandom_range(0, 9) == 0 ? 12'hfff : 12'($urandom);
      1: lvl = sb.lo;
      2: lvl = sb.hi;
      default: lvl = $urandom_range(0, 1) ? sb.lo - 12'($urandom_range(0, 2))
                                          : sb.hi + 12'($urandom_range(0, 2));
    endcase
    if ($urandom_range(0, 11) == 0)
      command(mode_t'($urandom_range(0, 7)),
              $urandom_range(0, 3) == 0 ? 16'($urandom) : pick_secs());
    else
      tick($urandom_range(0, 24) != 0, lvl,
           $urandom_range(0, 9) == 0 ? 8'd0 : 8'($urandom));
  endtask

  initial begin
    int sent;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset state, every command, extremes and corner cases.
    tick(1, 0, 8'hff);                    // off with nothing to do
    command(MODE_ON, 0);
    tick(1, 12'hfff, 8'h00);              // zero duty keeps the switch off
    tick(1, 0, 8'hff);                    // switch on at full duty
    command(MODE_DOWN, 0);
    tick(1, 0, 8'h01);                    // switch off, latch count
    command(MODE_TIMED, 16'hffff);
    tick(1, 0, 8'h80);                    // zero duration drops to off
    write_reg(REG_STEP_TARGET, 0);
    command(MODE_COUNT, 0);
    tick(1, 0, 8'h80);                    // zero target drops to off
    write_reg(REG_STEP_TARGET, 3);
    write_reg(REG_STEP_DIVISOR, 1);
    command(MODE_COUNT, 0);
    repeat (6) tick(1, 0, 8'h55);         // runs until the count passes the target
    write_reg(REG_AUTO_LOW, 12'h400);
    write_reg(REG_AUTO_HIGH, 12'h400);
    command(MODE_LEVEL, 0);
    tick(1, 12'h400, 8'h33);              // equal thresholds at level: no start
    tick(1, 12'h000, 8'h33);              // on, max on-time zero drops the mode
    tick(1, 12'h000, 8'h33);              // next tick switches off
    command(MODE_LEVEL2, 16'hffff);
    tick(0, 0, 8'hff);                    // disable forces the mode down
    command(mode_t'(3'd7), 16'hffff);     // unused code: ignored
    command(MODE_INTERVAL, 0);
    repeat (3) tick(1, 0, 8'hc3);         // zero phases toggle every tick
    write_reg(REG_DURATION, 16'hffff);
    write_reg(REG_STEP_DIVISOR, 16'hffff);
    write_reg(REG_STEP_TARGET, 32'hffff_ffff);
    write_reg(REG_AUTO_DELAY, 16'hffff);
    write_reg(REG_INTERVAL_ON, 16'hffff);
    write_reg(REG_INTERVAL_OFF, 16'hffff);

    // One stretch where second-scale timers actually expire.
    write_reg(REG_DURATION, 1);
    write_reg(REG_AUTO_DELAY, 0);
    write_reg(REG_INTERVAL_ON, 0);
    write_reg(REG_INTERVAL_OFF, 0);
    command(MODE_TIMED, 0);
    sent = 0;
    repeat (1004) begin tick(1, 12'($urandom), 8'($urandom_range(1, 255))); sent++; end

    // Random phases: new settings, then mostly enabled ticks with some commands.
    while (sent < RandomItems) begin
      int n;
      random_config();
      command(mode_t'($urandom_range(1, 6)), pick_secs());
      n = $urandom_range(30, 90);
      if (sent > RandomItems - 200) quiet = 1;
      if (sent > 1100 && sent < 1200) hold_req = 1;
      repeat (n) begin random_beat(); sent++; end
      if ($urandom_range(0, 5) == 0) begin
        s_tvalid <= 0;
        drain();
      end
    end
    s_tvalid <= 0;

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d beats (%0d commands), %0d mode and %0d state reports,",
             sb.n_in, sb.n_cmd, sb.n_mpub, sb.n_spub);
    $display("with random settings, stalls on both sides and one long output hold-off.");
    if (sb.errors == 0 && sb.result_q.size() == 0)
      $display("multi_mode_output_switch_controller verification clean");
    else
      $display("multi_mode_output_switch_controller verification failed");
    $finish;
  end
endmodule
